// ===== rtl/miller_rabin_prime_test_defines.svh =====
// Assertion macros shared by the prime test RTL.
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrpt_pkg.sv =====
// Shared constants and types for the prime test.
package mrpt_pkg;

    localparam int NUMBER_BITS = 31;
    localparam int CNT_W       = $clog2(NUMBER_BITS);
    localparam int STEP_W      = $clog2(NUMBER_BITS + 1);
    localparam int NUM_BASES   = 3;

    localparam logic [NUMBER_BITS-1:0] MR_BASES [NUM_BASES] = '{
        NUMBER_BITS'(2), NUMBER_BITS'(7), NUMBER_BITS'(61)
    };

    // Request to the modular multiplier: a and n held stable while it runs.
    typedef struct packed {
        logic                   start;
        logic [NUMBER_BITS-1:0] a;
        logic [NUMBER_BITS-1:0] b;
        logic [NUMBER_BITS-1:0] n;
    } mul_req_t;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [NUMBER_BITS-1:0] result;
    } mul_rsp_t;

endpackage

// ===== rtl/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: a * b mod n, one bit of b per cycle.
module mrpt_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  mrpt_pkg::mul_req_t req,
    output mrpt_pkg::mul_rsp_t rsp
);
    import mrpt_pkg::*;

    logic                   active_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [NUMBER_BITS-1:0] r_reg;
    logic [NUMBER_BITS-1:0] b_reg;
    logic [NUMBER_BITS-1:0] r_next;
    logic [NUMBER_BITS:0]   dbl;
    logic [NUMBER_BITS:0]   sum;
    logic [NUMBER_BITS:0]   n_ext;

    // r <- (2r + bit*a) mod n, with r, a < n; each partial stays below 2n.
    always_comb
    begin
        n_ext = {1'b0, req.n};
        dbl   = {r_reg, 1'b0};
        if (dbl >= n_ext)
        begin
            dbl = dbl - n_ext;
        end
        sum = dbl + (b_reg[NUMBER_BITS-1] ? {1'b0, req.a} : '0);
        if (sum >= n_ext)
        begin
            sum = sum - n_ext;
        end
        r_next = sum[NUMBER_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(NUMBER_BITS - 1);
            end
            else if (active_reg)
            begin
                if (cnt_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            r_reg <= '0;
            b_reg <= req.b;
        end
        else if (active_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[NUMBER_BITS-2:0], 1'b0};
        end
    end

    assign rsp.busy   = active_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule

// ===== rtl/miller_rabin_prime_test.sv =====
// Top level: deterministic Miller-Rabin primality test sequencer.
//
// Usage:
//   Drive number and raise start while busy is low; the word is taken at
//   that clock edge. One result word follows: done is high for exactly one
//   cycle with prime_flag valid in that cycle. The receiver cannot stall, so
//   prime_flag must be captured while done is high.
//   Zero, one, the bases themselves and even values are decided at once:
//   done comes in the cycle after start, with no multiplier work.
//   Odd values run bases 2, 7 and 61 in turn. Each base costs one reduction,
//   a square-and-multiply pass over d (the odd part of n-1) and up to s
//   squarings (s = trailing zeros of n-1), all on one bit-serial modular
//   multiplier. For a prime near 2^31 a run takes at most about 3 * 62
//   products; composites usually end after the first base. The multiplier
//   is the only arithmetic unit. For the remaining odd values, busy is
//   high from the cycle after start until done; a new start is taken in
//   the cycle done is high.
//   Reset (rst_n low, asynchronous) returns to idle, drops busy and done.
module miller_rabin_prime_test (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mrpt_pkg::NUMBER_BITS-1:0] number,
    output logic                             busy,
    output logic                             done,
    output logic                             prime_flag
);
    import mrpt_pkg::*;

    `include "miller_rabin_prime_test_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACTOR,
        ST_BASE,
        ST_POW,
        ST_SQ,
        ST_WAIT,
        ST_CHECK
    } state_t;

    // What the multiplier result is written back to.
    typedef enum logic [1:0] {
        OP_RED,
        OP_ACC,
        OP_SQ,
        OP_Y
    } op_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic [NUMBER_BITS-1:0] n_reg;
    logic [NUMBER_BITS-1:0] odd_reg;
    logic [NUMBER_BITS-1:0] e_reg;
    logic [NUMBER_BITS-1:0] acc_reg;
    logic [NUMBER_BITS-1:0] sq_reg;
    logic [NUMBER_BITS-1:0] y_reg;
    logic [STEP_W-1:0]      s_reg;
    logic [STEP_W-1:0]      j_reg;
    logic [1:0]             k_reg;
    logic                   mul_start_reg;
    logic [NUMBER_BITS-1:0] mul_a_reg;
    logic [NUMBER_BITS-1:0] mul_b_reg;
    logic                   done_reg;
    logic                   prime_flag_reg;

    logic [NUMBER_BITS-1:0] n_minus_1;
    logic                   keep_squaring;
    logic                   witness;
    mul_req_t               mul_req;
    mul_rsp_t               mul_rsp;

    assign n_minus_1 = n_reg - 1'b1;

    // Squaring loop: stop at 1 or n-1, or once the exponent reaches n-1.
    assign keep_squaring = (j_reg != s_reg) && (y_reg != NUMBER_BITS'(1))
                           && (y_reg != n_minus_1);
    // Base proves compositeness: final y is not n-1 after at least one square.
    assign witness = (y_reg != n_minus_1) && (j_reg != '0);

    assign mul_req.start = mul_start_reg;
    assign mul_req.a     = mul_a_reg;
    assign mul_req.b     = mul_b_reg;
    assign mul_req.n     = n_reg;

    mrpt_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_RED;
            n_reg          <= '0;
            odd_reg        <= '0;
            e_reg          <= '0;
            acc_reg        <= '0;
            sq_reg         <= '0;
            y_reg          <= '0;
            s_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            mul_start_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            done_reg       <= 1'b0;
            prime_flag_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        n_reg   <= number;
                        odd_reg <= number - 1'b1;
                        s_reg   <= '0;
                        k_reg   <= '0;
                        if (number <= NUMBER_BITS'(1))
                        begin
                            done_reg       <= 1'b1;
                            prime_flag_reg <= 1'b0;
                        end
                        else if (number == MR_BASES[0] || number == MR_BASES[1]
                                 || number == MR_BASES[2])
                        begin
                            done_reg       <= 1'b1;
                            prime_flag_reg <= 1'b1;
                        end
                        else if (!number[0])
                        begin
                            done_reg       <= 1'b1;
                            prime_flag_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_FACTOR;
                        end
                    end
                end

                // Strip trailing zeros of n-1, one per cycle.
                ST_FACTOR:
                begin
                    if (odd_reg[0])
                    begin
                        state_reg <= ST_BASE;
                    end
                    else
                    begin
                        odd_reg <= odd_reg >> 1;
                        s_reg   <= s_reg + 1'b1;
                    end
                end

                // Base mod n, computed as 1 * base on the multiplier.
                ST_BASE:
                begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg     <= NUMBER_BITS'(1);
                    mul_b_reg     <= MR_BASES[k_reg];
                    op_reg        <= OP_RED;
                    state_reg     <= ST_WAIT;
                end

                // Square-and-multiply, exponent LSB first.
                ST_POW:
                begin
                    if (e_reg == '0)
                    begin
                        y_reg     <= acc_reg;
                        j_reg     <= '0;
                        state_reg <= ST_CHECK;
                    end
                    else if (e_reg[0])
                    begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= acc_reg;
                        mul_b_reg     <= sq_reg;
                        op_reg        <= OP_ACC;
                        state_reg     <= ST_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_SQ;
                    end
                end

                ST_SQ:
                begin
                    mul_start_reg <= 1'b1;
                    mul_a_reg     <= sq_reg;
                    mul_b_reg     <= sq_reg;
                    op_reg        <= OP_SQ;
                    state_reg     <= ST_WAIT;
                end

                ST_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        case (op_reg)
                            OP_RED:
                            begin
                                sq_reg    <= mul_rsp.result;
                                acc_reg   <= NUMBER_BITS'(1);
                                e_reg     <= odd_reg;
                                state_reg <= ST_POW;
                            end
                            OP_ACC:
                            begin
                                acc_reg   <= mul_rsp.result;
                                state_reg <= ST_SQ;
                            end
                            OP_SQ:
                            begin
                                sq_reg    <= mul_rsp.result;
                                e_reg     <= e_reg >> 1;
                                state_reg <= ST_POW;
                            end
                            default:
                            begin
                                y_reg     <= mul_rsp.result;
                                j_reg     <= j_reg + 1'b1;
                                state_reg <= ST_CHECK;
                            end
                        endcase
                    end
                end

                ST_CHECK:
                begin
                    if (keep_squaring)
                    begin
                        mul_start_reg <= 1'b1;
                        mul_a_reg     <= y_reg;
                        mul_b_reg     <= y_reg;
                        op_reg        <= OP_Y;
                        state_reg     <= ST_WAIT;
                    end
                    else if (witness)
                    begin
                        done_reg       <= 1'b1;
                        prime_flag_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                    else if (k_reg == 2'(NUM_BASES - 1))
                    begin
                        done_reg       <= 1'b1;
                        prime_flag_reg <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_BASE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign prime_flag = prime_flag_reg;

    `MRPT_ASSERT_IMP(a_done_idle, done, !busy, "result word while sequencer busy")
    `MRPT_ASSERT_NXT(a_start_progress, start && !busy, busy || done,
        "accepted word neither decided nor started")
    `MRPT_ASSERT_IMP(a_mul_free, mul_req.start, !mul_rsp.busy,
        "multiplier launched while running")
    `MRPT_ASSERT_IMP(a_done_cause, done, $past(busy || start),
        "result word without a preceding request")

endmodule
